FILE: design/sst_pkg.sv
`default_nettype none

package sst_pkg;

    localparam logic [7:0] QUOTE_CODE   = 8'h22;
    localparam logic [7:0] NEWLINE_CODE = 8'h0a;
    localparam logic [15:0] COUNT_MAX   = 16'hffff;

    // output queue depth and its occupancy width
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_COUNT_W = $clog2(OUT_DEPTH + 1);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SEP_LOW    = 2'd0,
        REG_SEP_HIGH   = 2'd1,
        REG_STICKY_LOW = 2'd2,
        REG_STICKY_HIGH = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_TOKEN   = 2'd1,
        MODE_QUOTED  = 2'd2
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_buffer;
    } text_item_t;

    typedef struct packed {
        logic [7:0]  token_char;
        logic        last_of_token;
        logic        was_quoted;
        logic [15:0] token_line;
        logic [15:0] token_column;
    } token_item_t;

    typedef struct packed {
        scan_mode_t  mode;
        logic [7:0]  held_byte;
        logic        held_valid;
        logic        token_quoted;
        logic        first_is_newline;
        logic [15:0] line_count;
        logic [15:0] column_count;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        mode:             MODE_BETWEEN,
        held_byte:        8'd0,
        held_valid:       1'b0,
        token_quoted:     1'b0,
        first_is_newline: 1'b0,
        line_count:       16'd1,
        column_count:     16'd1
    };

    function automatic logic mask_hit(input logic [127:0] mask, input logic [7:0] b);
        mask_hit = !b[7] && mask[b[6:0]];
    endfunction

    // counter update when a token completes, both saturating
    function automatic scan_state_t advance_counters(input scan_state_t s, input logic nl_first);
        scan_state_t r;
        r = s;
        if (nl_first)
        begin
            if (s.line_count != COUNT_MAX)
            begin
                r.line_count = s.line_count + 16'd1;
            end
            r.column_count = 16'd1;
        end
        else if (s.column_count != COUNT_MAX)
        begin
            r.column_count = s.column_count + 16'd1;
        end
        return r;
    endfunction

    function automatic token_item_t make_token(input logic [7:0] c, input logic last,
                                               input logic quoted, input scan_state_t s);
        token_item_t t;
        t.token_char    = c;
        t.last_of_token = last;
        t.was_quoted    = quoted;
        t.token_line    = s.line_count;
        t.token_column  = s.column_count;
        return t;
    endfunction

endpackage

`default_nettype wire

FILE: design/sst_if.sv
`default_nettype none

interface sst_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_buffer;

    modport source (output valid, output text_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input text_byte, input end_of_buffer, output ready);
endinterface

interface sst_token_if;
    logic        valid;
    logic        ready;
    logic [7:0]  token_char;
    logic        last_of_token;
    logic        was_quoted;
    logic [15:0] token_line;
    logic [15:0] token_column;

    modport source (output valid, output token_char, output last_of_token,
                    output was_quoted, output token_line, output token_column,
                    input ready);
    modport sink   (input valid, input token_char, input last_of_token,
                    input was_quoted, input token_line, input token_column,
                    output ready);
endinterface

interface sst_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/sst_step.sv
`default_nettype none

// one byte of scanning: next state and zero to two token bytes
module sst_step
    import sst_pkg::*;
(
    input  scan_state_t  state,
    input  text_item_t   item,
    input  logic [127:0] sep_mask,
    input  logic [127:0] sticky_mask,
    output scan_state_t  state_next,
    output token_item_t  res [2],
    output logic [1:0]   res_count
);

    always_comb
    begin
        scan_state_t st;
        logic [7:0]  b;
        logic        normal;
        logic        sep;
        logic        sticky;
        logic [1:0]  n;

        st     = state;
        b      = item.text_byte;
        normal = 1'b1;
        n      = 2'd0;
        res[0] = '0;
        res[1] = '0;

        if (st.mode == MODE_QUOTED)
        begin
            if (b == QUOTE_CODE)
            begin
                st.mode = MODE_TOKEN;
                normal  = 1'b0;
            end
            else if (b == NEWLINE_CODE)
            begin
                st.mode = MODE_TOKEN;
            end
            else
            begin
                // add byte
                if (st.held_valid)
                begin
                    res[n[0]] = make_token(st.held_byte, 1'b0, st.token_quoted, st);
                    n = n + 2'd1;
                end
                else
                begin
                    st.first_is_newline = 1'b0;
                end
                st.held_byte  = b;
                st.held_valid = 1'b1;
                normal        = 1'b0;
            end
        end

        sep    = (b == 8'd0) || mask_hit(sep_mask, b);
        sticky = !sep && mask_hit(sticky_mask, b);

        if (normal)
        begin
            if (sep || sticky)
            begin
                // end of open token
                if (st.held_valid)
                begin
                    res[n[0]] = make_token(st.held_byte, 1'b1, st.token_quoted, st);
                    n = n + 2'd1;
                    st = advance_counters(st, st.first_is_newline);
                end
                st.held_valid       = 1'b0;
                st.held_byte        = 8'd0;
                st.token_quoted     = 1'b0;
                st.first_is_newline = 1'b0;
                st.mode             = MODE_BETWEEN;
                if (sticky)
                begin
                    res[n[0]] = make_token(b, 1'b1, 1'b0, st);
                    n = n + 2'd1;
                    st = advance_counters(st, b == NEWLINE_CODE);
                end
            end
            else if (b == QUOTE_CODE)
            begin
                st.token_quoted = 1'b1;
                st.mode         = MODE_QUOTED;
            end
            else
            begin
                if (st.held_valid)
                begin
                    res[n[0]] = make_token(st.held_byte, 1'b0, st.token_quoted, st);
                    n = n + 2'd1;
                end
                else
                begin
                    st.first_is_newline = (b == NEWLINE_CODE);
                end
                st.held_byte  = b;
                st.held_valid = 1'b1;
                st.mode       = MODE_TOKEN;
            end
        end

        if (item.end_of_buffer)
        begin
            if (st.held_valid)
            begin
                res[n[0]] = make_token(st.held_byte, 1'b1, st.token_quoted, st);
                n = n + 2'd1;
                st = advance_counters(st, st.first_is_newline);
            end
            st.held_valid       = 1'b0;
            st.held_byte        = 8'd0;
            st.token_quoted     = 1'b0;
            st.first_is_newline = 1'b0;
            st.mode             = MODE_BETWEEN;
        end

        state_next = st;
        res_count  = n;
    end

endmodule

`default_nettype wire

FILE: design/sticky_separator_tokenizer_top.sv
// an accepted byte waits in the input register; its token bytes pass the output queue
// throughput: one text item per cycle while the token side keeps up; the token
//   port delivers one item per cycle, so a two-result byte leaves its items one at a time
// the scan step fires when the four-entry output queue has room for two items
// reset (rst_n low, asynchronous): masks cleared, scanner between tokens, line and column 1
`default_nettype none

module sticky_separator_tokenizer_top
    import sst_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    sst_text_if.sink      text,
    sst_token_if.source   tokens,
    sst_cfg_if.sink       cfg
);

    // mask registers, low and high halves side by side
    logic [127:0] sep_mask_reg;
    logic [127:0] sticky_mask_reg;

    // input register
    logic        in_valid_reg;
    text_item_t  in_item_reg;

    // scanner state
    scan_state_t state_reg;
    scan_state_t state_next;

    // step results
    token_item_t step_res [2];
    logic [1:0]  step_count;

    // output queue
    token_item_t              queue_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]     wr_ptr_reg;
    logic [OUT_PTR_W-1:0]     rd_ptr_reg;
    logic [OUT_COUNT_W-1:0]   count_reg;

    logic text_fire;
    logic step_fire;
    logic pop;
    logic [1:0] push_count;

    // configuration is taken at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_mask_reg    <= '0;
            sticky_mask_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_SEP_LOW:     sep_mask_reg[63:0]      <= cfg.data;
                REG_SEP_HIGH:    sep_mask_reg[127:64]    <= cfg.data;
                REG_STICKY_LOW:  sticky_mask_reg[63:0]   <= cfg.data;
                REG_STICKY_HIGH: sticky_mask_reg[127:64] <= cfg.data;
                default:         sep_mask_reg            <= sep_mask_reg;
            endcase
        end
    end

    // the scan step consumes the input register when the queue can take two items
    assign step_fire = in_valid_reg && (count_reg <= OUT_COUNT_W'(OUT_DEPTH - 2));
    assign text.ready = !in_valid_reg || step_fire;
    assign text_fire  = text.valid && text.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (text.ready)
        begin
            in_valid_reg <= text.valid;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        if (text_fire)
        begin
            in_item_reg.text_byte     <= text.text_byte;
            in_item_reg.end_of_buffer <= text.end_of_buffer;
        end
    end

    sst_step u_step (
        .state       (state_reg),
        .item        (in_item_reg),
        .sep_mask    (sep_mask_reg),
        .sticky_mask (sticky_mask_reg),
        .state_next  (state_next),
        .res         (step_res),
        .res_count   (step_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCAN_RESET;
        end
        else if (step_fire)
        begin
            state_reg <= state_next;
        end
    end

    // queue bookkeeping
    assign push_count = step_fire ? step_count : 2'd0;
    assign pop        = tokens.valid && tokens.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(push_count);
            rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(pop);
            count_reg  <= count_reg + OUT_COUNT_W'(push_count) - OUT_COUNT_W'(pop);
        end
    end

    // queue storage, first result at the write pointer, second right after it
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= step_res[0];
        end
        if (push_count == 2'd2)
        begin
            queue_reg[wr_ptr_reg + OUT_PTR_W'(1)] <= step_res[1];
        end
    end

    // token port straight from the queue head
    assign tokens.valid         = (count_reg != '0);
    assign tokens.token_char    = queue_reg[rd_ptr_reg].token_char;
    assign tokens.last_of_token = queue_reg[rd_ptr_reg].last_of_token;
    assign tokens.was_quoted    = queue_reg[rd_ptr_reg].was_quoted;
    assign tokens.token_line    = queue_reg[rd_ptr_reg].token_line;
    assign tokens.token_column  = queue_reg[rd_ptr_reg].token_column;

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OUT_COUNT_W'(OUT_DEPTH))
        else $error("output queue overflow");

    // occupancy follows pushes and pops
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + OUT_COUNT_W'($past(push_count))
                              - OUT_COUNT_W'($past(pop)))
        else $error("queue count out of step");

    // a scan step never produces more than two items
    assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |-> step_count != 2'd3)
        else $error("scan step produced three items");

    // line number never goes backward
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> state_reg.line_count >= $past(state_reg.line_count))
        else $error("line count decreased");

    // an accepted byte lands in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        text_fire |=> in_valid_reg)
        else $error("accepted byte lost");

endmodule

`default_nettype wire
